@@ hdl/tsp_pkg.sv @@
// ----------------------------------------------------------------------------
// tsp_pkg: shared types and constants for the triplet site pattern counter
// Counter widths, pattern and pair indexes, and the per-site hit and
// count bundles passed between the classifier, counter bank and top level.
// ----------------------------------------------------------------------------
package tsp_pkg;

  // Saturation limit of every counter.
  localparam longint unsigned MAX_SITES = 64'd1048576;

  // Internal counters hold values up to MAX_SITES; the ports are fixed at 21 bits.
  localparam int CNT_W = $clog2(MAX_SITES + 64'd1);
  localparam int OUT_W = 21;
  localparam int BASE_W = 8;

  localparam int NUM_PATTERNS = 5;
  localparam int NUM_PAIRS = 3;

  // Pattern indexes, in output order.
  localparam int PAT_ALL_SAME = 0;
  localparam int PAT_FIRST_DIFFERS = 1;
  localparam int PAT_SECOND_DIFFERS = 2;
  localparam int PAT_THIRD_DIFFERS = 3;
  localparam int PAT_ALL_DIFFER = 4;

  // Pair indexes.
  localparam int PAIR_FIRST_SECOND = 0;
  localparam int PAIR_FIRST_THIRD = 1;
  localparam int PAIR_SECOND_THIRD = 2;

  typedef logic [BASE_W-1:0] base_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [OUT_W-1:0] out_cnt_t;

  localparam cnt_t CNT_MAX = cnt_t'(MAX_SITES);

  // Which counters one site increments.
  typedef struct packed {
    logic [NUM_PATTERNS-1:0] pattern;
    logic [NUM_PAIRS-1:0] pair_match;
    logic [NUM_PAIRS-1:0] pair_mismatch;
  } hit_t;

  // The full set of eleven counter values.
  typedef struct packed {
    cnt_t [NUM_PATTERNS-1:0] pattern;
    cnt_t [NUM_PAIRS-1:0] pair_match;
    cnt_t [NUM_PAIRS-1:0] pair_mismatch;
  } counts_t;

endpackage

@@ hdl/tsp_stream_ifs.sv @@
// ----------------------------------------------------------------------------
// tsp_stream_ifs: valid/ready channels of the triplet site pattern counter
// One interface carries alignment columns in, the other carries the
// eleven counts out at the end of each alignment.
// ----------------------------------------------------------------------------
interface tsp_site_if;
  logic valid;
  logic ready;
  tsp_pkg::base_t base_first;
  tsp_pkg::base_t base_second;
  tsp_pkg::base_t base_third;
  logic last_site;

  modport source (output valid, output base_first, output base_second,
                  output base_third, output last_site, input ready);
  modport sink (input valid, input base_first, input base_second,
                input base_third, input last_site, output ready);
endinterface

interface tsp_result_if;
  logic valid;
  logic ready;
  tsp_pkg::out_cnt_t count_all_same;
  tsp_pkg::out_cnt_t count_first_differs;
  tsp_pkg::out_cnt_t count_second_differs;
  tsp_pkg::out_cnt_t count_third_differs;
  tsp_pkg::out_cnt_t count_all_differ;
  tsp_pkg::out_cnt_t match_first_second;
  tsp_pkg::out_cnt_t mismatch_first_second;
  tsp_pkg::out_cnt_t match_first_third;
  tsp_pkg::out_cnt_t mismatch_first_third;
  tsp_pkg::out_cnt_t match_second_third;
  tsp_pkg::out_cnt_t mismatch_second_third;

  modport source (output valid, input ready,
                  output count_all_same, output count_first_differs,
                  output count_second_differs, output count_third_differs,
                  output count_all_differ,
                  output match_first_second, output mismatch_first_second,
                  output match_first_third, output mismatch_first_third,
                  output match_second_third, output mismatch_second_third);
  modport sink (input valid, output ready,
                input count_all_same, input count_first_differs,
                input count_second_differs, input count_third_differs,
                input count_all_differ,
                input match_first_second, input mismatch_first_second,
                input match_first_third, input mismatch_first_third,
                input match_second_third, input mismatch_second_third);
endinterface

@@ hdl/tsp_classify.sv @@
// ----------------------------------------------------------------------------
// tsp_classify: site classifier
// Checks the three bases for A, C, G or T and decides which pattern
// counter and which pair match or mismatch counters the site bumps.
// ----------------------------------------------------------------------------
module tsp_classify (
  input  tsp_pkg::base_t base_first,
  input  tsp_pkg::base_t base_second,
  input  tsp_pkg::base_t base_third,
  output tsp_pkg::hit_t  hit
);

  localparam tsp_pkg::base_t BASE_A = 8'h41;
  localparam tsp_pkg::base_t BASE_C = 8'h43;
  localparam tsp_pkg::base_t BASE_G = 8'h47;
  localparam tsp_pkg::base_t BASE_T = 8'h54;

  function automatic logic is_base(tsp_pkg::base_t b);
    return (b == BASE_A) || (b == BASE_C) || (b == BASE_G) || (b == BASE_T);
  endfunction

  logic v1, v2, v3;
  logic e12, e13, e23;

  assign v1 = is_base(base_first);
  assign v2 = is_base(base_second);
  assign v3 = is_base(base_third);

  assign e12 = (base_first == base_second);
  assign e13 = (base_first == base_third);
  assign e23 = (base_second == base_third);

  // Pattern select, only when all three bases are valid. Pair counts need
  // both bases of the pair to be valid.
  always_comb begin
    hit.pattern = '0;
    if (v1 && v2 && v3) begin
      if (e12 && e13) begin
        hit.pattern[tsp_pkg::PAT_ALL_SAME] = 1'b1;
      end else if (e23) begin
        hit.pattern[tsp_pkg::PAT_FIRST_DIFFERS] = 1'b1;
      end else if (e13) begin
        hit.pattern[tsp_pkg::PAT_SECOND_DIFFERS] = 1'b1;
      end else if (e12) begin
        hit.pattern[tsp_pkg::PAT_THIRD_DIFFERS] = 1'b1;
      end else begin
        hit.pattern[tsp_pkg::PAT_ALL_DIFFER] = 1'b1;
      end
    end
    hit.pair_match[tsp_pkg::PAIR_FIRST_SECOND] = v1 && v2 && e12;
    hit.pair_mismatch[tsp_pkg::PAIR_FIRST_SECOND] = v1 && v2 && !e12;
    hit.pair_match[tsp_pkg::PAIR_FIRST_THIRD] = v1 && v3 && e13;
    hit.pair_mismatch[tsp_pkg::PAIR_FIRST_THIRD] = v1 && v3 && !e13;
    hit.pair_match[tsp_pkg::PAIR_SECOND_THIRD] = v2 && v3 && e23;
    hit.pair_mismatch[tsp_pkg::PAIR_SECOND_THIRD] = v2 && v3 && !e23;
  end

endmodule

@@ hdl/tsp_counter_bank.sv @@
// ----------------------------------------------------------------------------
// tsp_counter_bank: eleven saturating site counters
// Bumps the counters selected by the hit vector on each advancing site
// and clears them all after the last site of an alignment.
// ----------------------------------------------------------------------------
module tsp_counter_bank (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              clear,
  input  tsp_pkg::hit_t     hit,
  output tsp_pkg::counts_t  counts_next
);

  tsp_pkg::counts_t counts;

  function automatic tsp_pkg::cnt_t bump(tsp_pkg::cnt_t c, logic inc);
    if (inc && (c < tsp_pkg::CNT_MAX)) begin
      return tsp_pkg::cnt_t'(c + 1'b1);
    end
    return c;
  endfunction

  // Incremented values, including the current site.
  always_comb begin
    for (int i = 0; i < tsp_pkg::NUM_PATTERNS; i++) begin
      counts_next.pattern[i] = bump(counts.pattern[i], hit.pattern[i]);
    end
    for (int i = 0; i < tsp_pkg::NUM_PAIRS; i++) begin
      counts_next.pair_match[i] = bump(counts.pair_match[i], hit.pair_match[i]);
      counts_next.pair_mismatch[i] = bump(counts.pair_mismatch[i], hit.pair_mismatch[i]);
    end
  end

  // Counter registers; the last site hands its totals on and starts over.
  always_ff @(posedge clk) begin
    if (rst) begin
      counts <= '0;
    end else if (advance) begin
      if (clear) begin
        counts <= '0;
      end else begin
        counts <= counts_next;
      end
    end
  end

endmodule

@@ hdl/triplet_site_pattern_counter.sv @@
// ----------------------------------------------------------------------------
// triplet_site_pattern_counter: three-taxon site pattern counter
// Counts the five three-way site patterns and the pairwise matches and
// mismatches over an alignment and emits all eleven counts at its end.
// ----------------------------------------------------------------------------
// The block takes one alignment column per cycle while nothing stalls and
// emits one transaction of eleven counts for each column marked as the last
// site. A column passes through an input register, then the classifier and
// the saturating counter bank update the counters, and the totals of a
// finished alignment land in a result register. Columns keep flowing while a
// result waits to be taken; only a second last site stalls until the previous
// result has left. Counters saturate at the package's MAX_SITES and ports
// carry the low 21 bits. Reset clears all counters.
module triplet_site_pattern_counter (
  input logic         clk,
  input logic         rst,
  tsp_site_if.sink    site,
  tsp_result_if.source result
);

  // Input register stage.
  logic            s1_valid;
  logic            s1_last;
  tsp_pkg::base_t  s1_first;
  tsp_pkg::base_t  s1_second;
  tsp_pkg::base_t  s1_third;

  // Result register.
  logic             res_valid;
  tsp_pkg::counts_t res_counts;

  tsp_pkg::hit_t    hit;
  tsp_pkg::counts_t counts_next;
  logic             advance;

  // A last site may move on only when the result register is free or draining.
  assign advance = s1_valid && !(s1_last && res_valid && !result.ready);
  assign site.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (site.ready) begin
      s1_valid <= site.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (site.valid && site.ready) begin
      s1_first <= site.base_first;
      s1_second <= site.base_second;
      s1_third <= site.base_third;
      s1_last <= site.last_site;
    end
  end

  tsp_classify u_classify (
    .base_first  (s1_first),
    .base_second (s1_second),
    .base_third  (s1_third),
    .hit         (hit)
  );

  tsp_counter_bank u_counter_bank (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .clear       (s1_last),
    .hit         (hit),
    .counts_next (counts_next)
  );

  // Capture the totals of a finished alignment.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && s1_last) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last) begin
      res_counts <= counts_next;
    end
  end

  // Result port, trimmed or extended to the port width.
  assign result.valid = res_valid;
  assign result.count_all_same =
    tsp_pkg::out_cnt_t'(res_counts.pattern[tsp_pkg::PAT_ALL_SAME]);
  assign result.count_first_differs =
    tsp_pkg::out_cnt_t'(res_counts.pattern[tsp_pkg::PAT_FIRST_DIFFERS]);
  assign result.count_second_differs =
    tsp_pkg::out_cnt_t'(res_counts.pattern[tsp_pkg::PAT_SECOND_DIFFERS]);
  assign result.count_third_differs =
    tsp_pkg::out_cnt_t'(res_counts.pattern[tsp_pkg::PAT_THIRD_DIFFERS]);
  assign result.count_all_differ =
    tsp_pkg::out_cnt_t'(res_counts.pattern[tsp_pkg::PAT_ALL_DIFFER]);
  assign result.match_first_second =
    tsp_pkg::out_cnt_t'(res_counts.pair_match[tsp_pkg::PAIR_FIRST_SECOND]);
  assign result.mismatch_first_second =
    tsp_pkg::out_cnt_t'(res_counts.pair_mismatch[tsp_pkg::PAIR_FIRST_SECOND]);
  assign result.match_first_third =
    tsp_pkg::out_cnt_t'(res_counts.pair_match[tsp_pkg::PAIR_FIRST_THIRD]);
  assign result.mismatch_first_third =
    tsp_pkg::out_cnt_t'(res_counts.pair_mismatch[tsp_pkg::PAIR_FIRST_THIRD]);
  assign result.match_second_third =
    tsp_pkg::out_cnt_t'(res_counts.pair_match[tsp_pkg::PAIR_SECOND_THIRD]);
  assign result.mismatch_second_third =
    tsp_pkg::out_cnt_t'(res_counts.pair_mismatch[tsp_pkg::PAIR_SECOND_THIRD]);

`ifndef SYNTHESIS
  // A pending last site must hold off new columns while the result is stuck.
  a_last_stall: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_last && res_valid && !result.ready) |-> !site.ready)
    else $error("new column accepted while last site is stalled");

  // A last site that moves on always yields a result next cycle.
  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_last) |=> result.valid)
    else $error("last site did not produce a result");

  // A waiting result is not disturbed by ordinary columns.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !result.ready) |=> $stable(res_counts))
    else $error("waiting result changed");

  // At most one pattern counter per site.
  a_one_pattern: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> $onehot0(hit.pattern))
    else $error("site hit more than one pattern");

  // A pair is never both a match and a mismatch.
  a_pair_exclusive: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> ((hit.pair_match & hit.pair_mismatch) == '0))
    else $error("pair counted as match and mismatch");
`endif

endmodule
